/* src/assert_macros.svh */
// Assertion helpers shared by the terminal writer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define TMTW_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define TMTW_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/tmtw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tmtw_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Cell layout: attribute byte over character byte
  localparam int CELL_W = 16;

  localparam logic [7:0] BLANK_CHAR  = 8'h20;
  localparam logic [7:0] RESET_COLOR = 8'h07;

  // Control characters
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;

  // Register byte addresses
  localparam logic [1:0] REG_TEXT_COLOR = 2'd0;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    FILL_INIT = 2'd0,
    FILL_TEXT = 2'd1,
    FILL_ITEM = 2'd2
  } fill_sel_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_COPY,
    ST_FILL,
    ST_CLEAR,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic      latch_in;
    logic      put_step;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      copy_rd;
    logic      copy_wr;
    logic      fill_wr;
    fill_sel_t fill_sel;
    logic      rd_issue;
    logic      clear_cursor;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_at_fill_start;
    logic cnt_at_end;
    logic scroll_need;
    logic out_blocked;
  } status_t;

endpackage

`default_nettype wire

/* src/text_mode_terminal_writer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Text-mode terminal writer: keeps a ROWS x COLUMNS store of 16-bit cells
// (attribute high byte, character low byte) in a single-port-write RAM and
// returns one result beat per input beat with the cursor after the step.
// After reset the block blanks the store before it takes its first beat
// (register writes are taken meanwhile). A put that scrolls moves or blanks
// every cell through the one RAM write port, one cell a cycle; a clear blanks
// every cell the same way. A result that waits on out_stall does not keep the
// next beat out, but holds the controller in the final step of that beat.
module text_mode_terminal_writer #(
  parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  char_code,
  input  logic        use_own_color,
  input  logic [7:0]  own_color,
  input  logic [10:0] cell_index,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  cursor_column,
  output logic [4:0]  cursor_line,
  output logic [10:0] cursor_position,
  output logic [15:0] cell_data
);

  logic              [7:0] text_color;
  tmtw_pkg::cmd_t          cmd;
  tmtw_pkg::status_t       status;

  // Register write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= tmtw_pkg::RESET_COLOR;
    end else if (psel && penable && pwrite && pready
                 && paddr == tmtw_pkg::REG_TEXT_COLOR) begin
      text_color <= pwdata[7:0];
    end
  end

  // Register read back
  assign pready = 1'b1;
  assign prdata = (paddr == tmtw_pkg::REG_TEXT_COLOR) ? {24'd0, text_color} : 32'd0;

  tmtw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  tmtw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .text_color      (text_color),
    .action          (action),
    .char_code       (char_code),
    .use_own_color   (use_own_color),
    .own_color       (own_color),
    .cell_index      (cell_index),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .cursor_column   (cursor_column),
    .cursor_line     (cursor_line),
    .cursor_position (cursor_position),
    .cell_data       (cell_data)
  );

endmodule

`default_nettype wire

/* src/tmtw_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tmtw_ram #(
  parameter int WIDTH = tmtw_pkg::CELL_W,
  parameter int DEPTH = tmtw_pkg::DEF_ROWS * tmtw_pkg::DEF_COLUMNS,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/tmtw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tmtw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         action,
  output logic               in_stall,
  output tmtw_pkg::cmd_t     cmd,
  input  tmtw_pkg::status_t  status
);

  tmtw_pkg::state_t state;
  tmtw_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmtw_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      tmtw_pkg::ST_INIT: begin
        // blank the store after reset
        cmd.fill_wr  = 1'b1;
        cmd.fill_sel = tmtw_pkg::FILL_INIT;
        if (status.cnt_at_end) begin
          state_next = tmtw_pkg::ST_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      tmtw_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          cmd.cnt_clr  = 1'b1;
          case (action)
            tmtw_pkg::ACT_PUT:   state_next = tmtw_pkg::ST_PUT;
            tmtw_pkg::ACT_CLEAR: state_next = tmtw_pkg::ST_CLEAR;
            tmtw_pkg::ACT_READ:  state_next = tmtw_pkg::ST_READ;
            default:             state_next = tmtw_pkg::ST_DONE;
          endcase
        end
      end
      tmtw_pkg::ST_PUT: begin
        cmd.put_step = 1'b1;
        if (status.scroll_need) begin
          cmd.cnt_clr = 1'b1;
          state_next  = tmtw_pkg::ST_COPY;
        end else begin
          state_next = tmtw_pkg::ST_DONE;
        end
      end
      tmtw_pkg::ST_COPY: begin
        // read one row ahead, write back what the previous cycle read
        cmd.copy_rd = !status.cnt_at_fill_start;
        cmd.copy_wr = !status.cnt_zero;
        if (status.cnt_at_fill_start) begin
          state_next = tmtw_pkg::ST_FILL;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      tmtw_pkg::ST_FILL: begin
        cmd.fill_wr  = 1'b1;
        cmd.fill_sel = tmtw_pkg::FILL_ITEM;
        if (status.cnt_at_end) begin
          state_next = tmtw_pkg::ST_DONE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      tmtw_pkg::ST_CLEAR: begin
        cmd.fill_wr      = 1'b1;
        cmd.fill_sel     = tmtw_pkg::FILL_TEXT;
        cmd.clear_cursor = 1'b1;
        if (status.cnt_at_end) begin
          state_next = tmtw_pkg::ST_DONE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      tmtw_pkg::ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = tmtw_pkg::ST_DONE;
      end
      tmtw_pkg::ST_DONE: begin
        // hold until the output register has room
        if (!status.out_blocked) begin
          cmd.load_out = 1'b1;
          state_next   = tmtw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tmtw_pkg::ST_IDLE;
      end
    endcase
  end

  `TMTW_ASSERT(a_accept_goes_busy, clk, rst, (in_valid && !in_stall) |=> in_stall, "accepted beat did not stall the input")
  `TMTW_ASSERT_ALWAYS(a_reset_to_init, clk, rst |=> (state == tmtw_pkg::ST_INIT), "reset did not start the blanking pass")

endmodule

`default_nettype wire

/* src/tmtw_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tmtw_dp #(
  parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
  input  logic               clk,
  input  logic               rst,
  input  tmtw_pkg::cmd_t     cmd,
  output tmtw_pkg::status_t  status,
  input  logic [7:0]         text_color,
  input  logic [1:0]         action,
  input  logic [7:0]         char_code,
  input  logic               use_own_color,
  input  logic [7:0]         own_color,
  input  logic [10:0]        cell_index,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [6:0]         cursor_column,
  output logic [4:0]         cursor_line,
  output logic [10:0]        cursor_position,
  output logic [15:0]        cell_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [31:0] COLS_W  = 32'(COLUMNS);
  localparam logic [31:0] ROWS_W  = 32'(ROWS);
  localparam logic [31:0] CELLS_W = 32'(CELLS);

  // Latched item
  logic [1:0]  act_q;
  logic [7:0]  char_q;
  logic [7:0]  color_q;
  logic [10:0] idx_q;

  // Cursor and sweep counter
  logic [CW-1:0]   col;
  logic [RW-1:0]   row;
  logic [CNTW-1:0] cnt;

  // Put decode
  logic [CW:0]   col_inc;
  logic [CW:0]   tab_col;
  logic [RW:0]   row_inc;
  logic [CW-1:0] col_n;
  logic [RW:0]   row_n;
  logic [CW-1:0] wcol;
  logic          put_we;
  logic [7:0]    put_char;
  logic          scroll_need;

  // Memory side
  logic [31:0]           put_addr_full;
  logic [31:0]           copy_raddr_full;
  logic [31:0]           idx_full;
  logic [CNTW-1:0]       cnt_m1;
  logic                  idx_ok;
  logic [15:0]           fill_cell;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [15:0]           mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [15:0]           mem_rdata;
  logic [31:0]           pos_full;

  // Work out the cursor move and cell write of a put
  always_comb begin
    col_inc  = (CW+1)'(col) + (CW+1)'(1);
    tab_col  = ((CW+1)'(col) + (CW+1)'(4)) & ~(CW+1)'(3);
    row_inc  = (RW+1)'(row) + (RW+1)'(1);
    col_n    = col;
    row_n    = (RW+1)'(row);
    wcol     = col;
    put_we   = 1'b0;
    put_char = char_q;
    case (char_q)
      tmtw_pkg::CH_NEWLINE: begin
        col_n = '0;
        row_n = row_inc;
      end
      tmtw_pkg::CH_RETURN: begin
        col_n = '0;
      end
      tmtw_pkg::CH_TAB: begin
        if (32'(tab_col) >= COLS_W) begin
          col_n = '0;
          row_n = row_inc;
        end else begin
          col_n = tab_col[CW-1:0];
        end
      end
      tmtw_pkg::CH_BACKSPACE: begin
        // nothing at column zero
        if (col != '0) begin
          col_n    = col - CW'(1);
          wcol     = col - CW'(1);
          put_we   = 1'b1;
          put_char = tmtw_pkg::BLANK_CHAR;
        end
      end
      default: begin
        put_we = 1'b1;
        if (32'(col_inc) >= COLS_W) begin
          col_n = '0;
          row_n = row_inc;
        end else begin
          col_n = col_inc[CW-1:0];
        end
      end
    endcase
    scroll_need = 32'(row_n) >= ROWS_W;
  end

  // Blank cell for the active sweep
  always_comb begin
    case (cmd.fill_sel)
      tmtw_pkg::FILL_INIT: fill_cell = {tmtw_pkg::RESET_COLOR, tmtw_pkg::BLANK_CHAR};
      tmtw_pkg::FILL_TEXT: fill_cell = {text_color, tmtw_pkg::BLANK_CHAR};
      tmtw_pkg::FILL_ITEM: fill_cell = {color_q, tmtw_pkg::BLANK_CHAR};
      default:             fill_cell = {color_q, tmtw_pkg::BLANK_CHAR};
    endcase
  end

  // Select memory addresses and data
  always_comb begin
    put_addr_full   = 32'(row) * COLS_W + 32'(wcol);
    copy_raddr_full = 32'(cnt) + COLS_W;
    idx_full        = 32'(idx_q);
    idx_ok          = idx_full < CELLS_W;
    cnt_m1          = cnt - CNTW'(1);

    mem_we    = 1'b0;
    mem_waddr = put_addr_full[AW-1:0];
    mem_wdata = {color_q, put_char};
    if (cmd.copy_wr) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_m1[AW-1:0];
      mem_wdata = mem_rdata;
    end else if (cmd.fill_wr) begin
      mem_we    = 1'b1;
      mem_waddr = cnt[AW-1:0];
      mem_wdata = fill_cell;
    end else if (cmd.put_step && put_we) begin
      mem_we = 1'b1;
    end

    mem_re    = cmd.copy_rd || (cmd.rd_issue && idx_ok);
    mem_raddr = cmd.copy_rd ? copy_raddr_full[AW-1:0] : idx_full[AW-1:0];
  end

  tmtw_ram #(
    .WIDTH (tmtw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Status back to the controller
  always_comb begin
    status.cnt_zero          = (cnt == '0);
    status.cnt_at_fill_start = (32'(cnt) == CELLS_W - COLS_W);
    status.cnt_at_end        = (32'(cnt) == CELLS_W - 32'd1);
    status.scroll_need       = scroll_need;
    status.out_blocked       = out_valid && out_stall;
  end

  // Cursor, counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + CNTW'(1);
      end
      if (cmd.clear_cursor) begin
        col <= '0;
        row <= '0;
      end else if (cmd.put_step) begin
        col <= col_n;
        row <= scroll_need ? RW'(ROWS - 1) : row_n[RW-1:0];
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign pos_full = 32'(row) * COLS_W + 32'(col);

  // Capture the item and the result beat
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      act_q   <= action;
      char_q  <= char_code;
      color_q <= use_own_color ? own_color : text_color;
      idx_q   <= cell_index;
    end
    if (cmd.load_out) begin
      cursor_column   <= 7'(col);
      cursor_line     <= 5'(row);
      cursor_position <= pos_full[10:0];
      cell_data       <= (act_q == tmtw_pkg::ACT_READ && idx_ok) ? mem_rdata : 16'd0;
    end
  end

  `TMTW_ASSERT(a_load_has_room, clk, rst, cmd.load_out |-> !(out_valid && out_stall), "result loaded over a waiting beat")
  `TMTW_ASSERT(a_write_in_range, clk, rst, mem_we |-> (32'(mem_waddr) < CELLS_W), "cell write beyond the store")

endmodule

`default_nettype wire
